// ===== rtl/ipv6p_pkg.sv =====
package ipv6p_pkg;

    // Address geometry
    localparam int NUM_GROUPS  = 8;
    localparam int MAX_DIGITS  = 4;
    localparam int GROUP_BITS  = 16;
    localparam int GIDX_BITS   = $clog2(NUM_GROUPS);
    localparam int GCOUNT_BITS = $clog2(NUM_GROUPS + 1);

    typedef logic [GROUP_BITS-1:0] group_t;
    typedef logic [NUM_GROUPS-1:0][GROUP_BITS-1:0] group_array_t;
    typedef logic [GCOUNT_BITS-1:0] gcount_t;

    // Summary of a finished parse, handed to the gap expansion
    typedef struct packed {
        logic    ok;
        logic    gap_seen;
        gcount_t gap_position;
        gcount_t group_count;
    } parse_info_t;

endpackage

// ===== rtl/ipv6p_expand.sv =====
module ipv6p_expand
(
    input  ipv6p_pkg::group_array_t groups,
    input  ipv6p_pkg::parse_info_t  info,
    output logic [63:0]             address_high,
    output logic [63:0]             address_low
);

    ipv6p_pkg::gcount_t     zeros;
    ipv6p_pkg::gcount_t     gap_end;
    ipv6p_pkg::group_array_t words;

    // Number of zero groups the gap stands for
    assign zeros   = ipv6p_pkg::GCOUNT_BITS'(ipv6p_pkg::NUM_GROUPS) - info.group_count;
    assign gap_end = info.gap_position + zeros;

    // Eight-way selection per output group
    always_comb
    begin
        for (int i = 0; i < ipv6p_pkg::NUM_GROUPS; i++)
        begin
            if (!info.ok)
            begin
                words[i] = '0;
            end
            else if (!info.gap_seen ||
                     ipv6p_pkg::GCOUNT_BITS'(i) < info.gap_position)
            begin
                words[i] = groups[i];
            end
            else if (ipv6p_pkg::GCOUNT_BITS'(i) < gap_end)
            begin
                words[i] = '0;
            end
            else
            begin
                words[i] = groups[ipv6p_pkg::GIDX_BITS'(ipv6p_pkg::GCOUNT_BITS'(i) - zeros)];
            end
        end
    end

    assign address_high = {words[0], words[1], words[2], words[3]};
    assign address_low  = {words[4], words[5], words[6], words[7]};

endmodule

// ===== rtl/ipv6_text_address_parser_core.sv =====
// Channel  Signals                               Direction  Transaction
// -------  ------------------------------------  ---------  ---------------------------
// in       in_valid/in_stall, character,          input      one character or terminator
//          end_of_text
// out      out_valid/out_stall, address_valid,    output     one parsed address
//          address_high, address_low
//
// One character is taken per cycle while in_stall is low; the parser state updates at the accepting edge.
// The terminator's result is registered and appears in the cycle after acceptance.
// in_stall is raised only while a result waits in the output register under out_stall.
// rst_n clears the parser to the start of text and empties the output register.
module ipv6_text_address_parser_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  character,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        address_valid,
    output logic [63:0] address_high,
    output logic [63:0] address_low
);

    typedef enum logic [2:0]
    {
        PH_START,
        PH_LEAD_COLON,
        PH_IN_GROUP,
        PH_AFTER_COLON,
        PH_AFTER_GAP
    } phase_t;

    // Hex decode: bit 4 flags a digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
            r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    localparam logic [7:0] COLON = 8'h3A;

    phase_t                  phase_reg, phase_next;
    ipv6p_pkg::group_array_t store_reg, store_next;
    ipv6p_pkg::gcount_t      count_reg, count_next;
    logic                    gap_seen_reg, gap_seen_next;
    ipv6p_pkg::gcount_t      gap_pos_reg, gap_pos_next;
    logic [2:0]              digit_reg, digit_next;
    ipv6p_pkg::group_t       value_reg, value_next;
    logic                    failed_reg, failed_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    addr_ok_reg;
    logic [63:0]             high_reg, low_reg;

    logic                    accept;
    logic [4:0]              hex;
    logic                    is_hex;
    logic                    is_colon;
    logic                    closing;
    ipv6p_pkg::group_array_t final_groups;
    ipv6p_pkg::parse_info_t  info;
    logic [63:0]             exp_high, exp_low;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign hex      = hex_decode(character);
    assign is_hex   = hex[4];
    assign is_colon = (character == COLON);

    // Parser next state
    always_comb
    begin
        phase_next    = phase_reg;
        store_next    = store_reg;
        count_next    = count_reg;
        gap_seen_next = gap_seen_reg;
        gap_pos_next  = gap_pos_reg;
        digit_next    = digit_reg;
        value_next    = value_reg;
        failed_next   = failed_reg;

        if (accept && end_of_text)
        begin
            phase_next    = PH_START;
            count_next    = '0;
            gap_seen_next = 1'b0;
            gap_pos_next  = '0;
            digit_next    = '0;
            value_next    = '0;
            failed_next   = 1'b0;
        end
        else if (accept && !failed_reg)
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (is_colon)
                    begin
                        phase_next = PH_LEAD_COLON;
                    end
                    else if (is_hex)
                    begin
                        value_next = ipv6p_pkg::GROUP_BITS'(hex[3:0]);
                        digit_next = 3'd1;
                        phase_next = PH_IN_GROUP;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_LEAD_COLON:
                begin
                    if (is_colon)
                    begin
                        gap_seen_next = 1'b1;
                        gap_pos_next  = '0;
                        phase_next    = PH_AFTER_GAP;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_IN_GROUP:
                begin
                    if (is_hex)
                    begin
                        if (digit_reg >= 3'(ipv6p_pkg::MAX_DIGITS))
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            value_next = {value_reg[ipv6p_pkg::GROUP_BITS-5:0], hex[3:0]};
                            digit_next = digit_reg + 3'd1;
                        end
                    end
                    else if (is_colon)
                    begin
                        store_next[count_reg[ipv6p_pkg::GIDX_BITS-1:0]] = value_reg;
                        count_next = count_reg + ipv6p_pkg::gcount_t'(1);
                        value_next = '0;
                        digit_next = '0;
                        phase_next = PH_AFTER_COLON;
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                PH_AFTER_COLON, PH_AFTER_GAP:
                begin
                    if (is_colon && phase_reg == PH_AFTER_COLON)
                    begin
                        if (gap_seen_reg)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            gap_seen_next = 1'b1;
                            gap_pos_next  = count_reg;
                            phase_next    = PH_AFTER_GAP;
                        end
                    end
                    else if (is_hex)
                    begin
                        if (count_reg >= ipv6p_pkg::GCOUNT_BITS'(ipv6p_pkg::NUM_GROUPS))
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            value_next = ipv6p_pkg::GROUP_BITS'(hex[3:0]);
                            digit_next = 3'd1;
                            phase_next = PH_IN_GROUP;
                        end
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
                default:
                begin
                    failed_next = 1'b1;
                end
            endcase
        end
    end

    // Close the open group for the terminator
    assign closing = (phase_reg == PH_IN_GROUP);

    always_comb
    begin
        final_groups = store_reg;
        if (closing)
            final_groups[count_reg[ipv6p_pkg::GIDX_BITS-1:0]] = value_reg;
    end

    always_comb
    begin
        info.group_count  = count_reg + ipv6p_pkg::GCOUNT_BITS'(closing);
        info.gap_seen     = gap_seen_reg;
        info.gap_position = gap_pos_reg;
        info.ok           = !failed_reg && (closing || phase_reg == PH_AFTER_GAP) &&
                            (gap_seen_reg ||
                             info.group_count ==
                             ipv6p_pkg::GCOUNT_BITS'(ipv6p_pkg::NUM_GROUPS));
    end

    ipv6p_expand u_expand
    (
        .groups       (final_groups),
        .info         (info),
        .address_high (exp_high),
        .address_low  (exp_low)
    );

    // Output register control
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept && end_of_text)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            count_reg     <= '0;
            gap_seen_reg  <= 1'b0;
            gap_pos_reg   <= '0;
            digit_reg     <= '0;
            value_reg     <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            gap_seen_reg  <= gap_seen_next;
            gap_pos_reg   <= gap_pos_next;
            digit_reg     <= digit_next;
            value_reg     <= value_next;
            failed_reg    <= failed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
        if (accept && end_of_text)
        begin
            addr_ok_reg <= info.ok;
            high_reg    <= exp_high;
            low_reg     <= exp_low;
        end
    end

    assign out_valid     = out_valid_reg;
    assign address_valid = addr_ok_reg;
    assign address_high  = high_reg;
    assign address_low   = low_reg;

endmodule
